// File: rtl/lj2z_pkg.sv
// Shared types, constants and output conversion functions for the two-zone pair force core.
package lj2z_pkg;

    localparam int MAG_W     = 48;
    localparam int COORD_W   = 32;
    localparam int SCALE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int HALF_W    = MAG_W / 2;

    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = MAG_W / DIV_STEPS;

    localparam logic [MAG_W-1:0]   MAG_MAX     = {MAG_W{1'b1}};
    localparam logic [MAG_W-1:0]   OUT_POS_MAX = {1'b0, {(MAG_W-1){1'b1}}};
    localparam logic [MAG_W-1:0]   OUT_NEG_MAG = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic [SCALE_W-1:0] SCALE_ONE   = {1'b1, {(SCALE_W-1){1'b0}}};
    localparam int                 SCALE_FRAC  = SCALE_W - 1;
    localparam int                 COEF_FRAC   = 24;

    typedef enum logic [1:0] {
        ZONE_BEYOND = 2'd0,
        ZONE_INNER  = 2'd1,
        ZONE_OUTER  = 2'd2
    } zone_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INNER_CUT_SQ    = 3'd0,
        REG_OUTER_CUT_SQ    = 3'd1,
        REG_FORCE_REP_COEF  = 3'd2,
        REG_FORCE_ATT_COEF  = 3'd3,
        REG_ENERGY_REP_COEF = 3'd4,
        REG_ENERGY_ATT_COEF = 3'd5,
        REG_OUTER_SCALE     = 3'd6,
        REG_ENERGY_ENABLE   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [MAG_W-1:0] force_x;
        logic [MAG_W-1:0] force_y;
        logic [MAG_W-1:0] force_z;
        logic [MAG_W-1:0] pair_energy;
        zone_t            zone;
        logic             saturated;
    } result_t;

    // Sign and magnitude to two's complement, clamped to the signed range.
    function automatic logic [MAG_W-1:0] out_word(input logic neg, input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] m;
        if (!neg) begin
            m = (mag > OUT_POS_MAX) ? OUT_POS_MAX : mag;
            return m;
        end
        m = (mag > OUT_NEG_MAG) ? OUT_NEG_MAG : mag;
        return ~m + MAG_W'(1);
    endfunction

    function automatic logic out_clip(input logic neg, input logic [MAG_W-1:0] mag);
        return neg ? (mag > OUT_NEG_MAG) : (mag > OUT_POS_MAX);
    endfunction

endpackage

// File: rtl/lj2z_delay.sv
// Enabled shift register that keeps side data in step with the arithmetic pipeline.
module lj2z_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [D];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++)
            begin
                pipe_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < D; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[D-1];

endmodule

// File: rtl/lj2z_mul.sv
// Three-stage unsigned multiplier with right shift, magnitude clamp and saturation flag.
module lj2z_mul #(
    parameter int SH = 24
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [lj2z_pkg::MAG_W-1:0] a,
    input  logic [lj2z_pkg::MAG_W-1:0] b,
    input  logic                   sat_in,
    output logic [lj2z_pkg::MAG_W-1:0] mag,
    output logic                   sat_out
);
    import lj2z_pkg::*;

    logic [MAG_W-1:0]  pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic              sat1_reg, sat2_reg, sat3_reg;
    logic [PROD_W-1:0] prod_next, prod_reg;
    logic [PROD_W-1:0] shifted;
    logic              over;
    logic [MAG_W-1:0]  mag_next, mag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg <= a[HALF_W-1:0] * b[HALF_W-1:0];
            pp01_reg <= a[HALF_W-1:0] * b[MAG_W-1:HALF_W];
            pp10_reg <= a[MAG_W-1:HALF_W] * b[HALF_W-1:0];
            pp11_reg <= a[MAG_W-1:HALF_W] * b[MAG_W-1:HALF_W];
            sat1_reg <= sat_in;
            prod_reg <= prod_next;
            sat2_reg <= sat1_reg;
            mag_reg  <= mag_next;
            sat3_reg <= sat2_reg | over;
        end
    end

    always_comb
    begin
        prod_next = PROD_W'(pp00_reg)
                  + (PROD_W'(pp01_reg) << HALF_W)
                  + (PROD_W'(pp10_reg) << HALF_W)
                  + (PROD_W'(pp11_reg) << MAG_W);
        shifted   = prod_reg >> SH;
        over      = |shifted[PROD_W-1-SH:MAG_W];
        mag_next  = over ? MAG_MAX : shifted[MAG_W-1:0];
    end

    assign mag     = mag_reg;
    assign sat_out = sat3_reg;

endmodule

// File: rtl/lj2z_div.sv
// Pipelined restoring divider giving the reciprocal of the scaled squared distance.
module lj2z_div #(
    parameter int DW = 40
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [DW-1:0]              divisor,
    output logic [lj2z_pkg::MAG_W-1:0] quot
);
    import lj2z_pkg::*;

    localparam int RW = DW + 1;

    logic [RW-1:0]    rem_s [DIV_STAGES+1];
    logic [MAG_W-1:0] quo_s [DIV_STAGES+1];
    logic [DW-1:0]    dvs_s [DIV_STAGES+1];

    assign rem_s[0] = RW'(1);
    assign quo_s[0] = '0;
    assign dvs_s[0] = divisor;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [RW-1:0]    rem_next, rem_reg;
        logic [MAG_W-1:0] quo_next, quo_reg;
        logic [DW-1:0]    dvs_reg;

        always_comb
        begin
            rem_next = rem_s[s];
            quo_next = quo_s[s];
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                rem_next = {rem_next[RW-2:0], 1'b0};
                if (rem_next >= {1'b0, dvs_s[s]})
                begin
                    rem_next = rem_next - {1'b0, dvs_s[s]};
                    quo_next = {quo_next[MAG_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_next[MAG_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                dvs_reg <= dvs_s[s];
            end
        end

        assign rem_s[s+1] = rem_reg;
        assign quo_s[s+1] = quo_reg;
        assign dvs_s[s+1] = dvs_reg;
    end

    assign quot = quo_s[DIV_STAGES] | MAG_W'(rem_s[DIV_STAGES] & RW'(0));

endmodule

// File: rtl/lj_pair_force_two_zone_core.sv
// Top level of the two-zone Lennard-Jones pair force pipeline.
// Throughput: one pair word per cycle while in_ready is high; the 24-stage reciprocal divider sets the depth.
// A two-word output buffer parts the sides; in_ready drops only while its spare slot is full.
// Reset clears the valid bits and loads the register defaults (outer scale one).
module lj_pair_force_two_zone_core #(
    parameter int COORD_FRAC_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lj2z_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lj2z_pkg::MAG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [lj2z_pkg::COORD_W-1:0] disp_x,
    input  logic signed [lj2z_pkg::COORD_W-1:0] disp_y,
    input  logic signed [lj2z_pkg::COORD_W-1:0] disp_z,
    input  logic [lj2z_pkg::SCALE_W-1:0]        bond_factor,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [lj2z_pkg::MAG_W-1:0]   force_x,
    output logic signed [lj2z_pkg::MAG_W-1:0]   force_y,
    output logic signed [lj2z_pkg::MAG_W-1:0]   force_z,
    output logic signed [lj2z_pkg::MAG_W-1:0]   pair_energy,
    output logic [1:0]                          zone,
    output logic                                saturated
);
    import lj2z_pkg::*;

    localparam int SQ_W  = 2 * COORD_W;
    localparam int SH_R  = 2 * COORD_FRAC_BITS - COEF_FRAC;
    localparam int RQW   = SQ_W - SH_R;
    localparam int CMPW  = (RQW > MAG_W) ? RQW : MAG_W;
    localparam int PIPE_D = 53;

    // Configuration registers.
    logic [MAG_W-1:0]   inner_cut_sq_reg, outer_cut_sq_reg;
    logic [MAG_W-1:0]   force_rep_coef_reg, force_att_coef_reg;
    logic [MAG_W-1:0]   energy_rep_coef_reg, energy_att_coef_reg;
    logic [SCALE_W-1:0] outer_scale_reg;
    logic               energy_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_cut_sq_reg    <= '0;
            outer_cut_sq_reg    <= '0;
            force_rep_coef_reg  <= '0;
            force_att_coef_reg  <= '0;
            energy_rep_coef_reg <= '0;
            energy_att_coef_reg <= '0;
            outer_scale_reg     <= SCALE_ONE;
            energy_enable_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_INNER_CUT_SQ:    inner_cut_sq_reg    <= cfg_data;
                REG_OUTER_CUT_SQ:    outer_cut_sq_reg    <= cfg_data;
                REG_FORCE_REP_COEF:  force_rep_coef_reg  <= cfg_data;
                REG_FORCE_ATT_COEF:  force_att_coef_reg  <= cfg_data;
                REG_ENERGY_REP_COEF: energy_rep_coef_reg <= cfg_data;
                REG_ENERGY_ATT_COEF: energy_att_coef_reg <= cfg_data;
                REG_OUTER_SCALE:     outer_scale_reg     <= cfg_data[SCALE_W-1:0];
                REG_ENERGY_ENABLE:   energy_enable_reg   <= cfg_data[0];
                default:             energy_enable_reg   <= energy_enable_reg;
            endcase
        end
    end

    // The whole pipeline moves together while the spare output slot is empty.
    logic en;
    logic skid_valid_reg, skid_valid_next;
    logic out_valid_reg, out_valid_next;
    result_t skid_data_reg, skid_data_next, out_data_reg, out_data_next;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // Stage 1: coordinate magnitudes and signs; then their squares and the sum of the squares.
    logic signed [COORD_W-1:0] disp_in [3];
    logic [COORD_W-1:0] mag_reg [3];
    logic [2:0]         neg_reg;
    logic [SCALE_W-1:0] bf_reg;
    logic [SQ_W-1:0]    sq_reg [3];
    logic [SQ_W-1:0]    rsq_reg;

    assign disp_in[0] = disp_x;
    assign disp_in[1] = disp_y;
    assign disp_in[2] = disp_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[k] <= disp_in[k][COORD_W-1];
                mag_reg[k] <= disp_in[k][COORD_W-1] ? (~disp_in[k] + COORD_W'(1))
                                                     : disp_in[k];
                sq_reg[k]  <= mag_reg[k] * mag_reg[k];
            end
            bf_reg  <= bond_factor;
            rsq_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    // Stage 4: zone classification and divisor.
    logic [RQW-1:0]  hi_c;
    logic            lo_zero;
    logic [CMPW-1:0] hi_x, inner_x, outer_x;
    zone_t           zone_next, zone_reg;
    logic [RQW-1:0]  rq_reg;
    logic            rqsat_reg;

    always_comb
    begin
        hi_c    = rsq_reg[SQ_W-1:SH_R];
        lo_zero = (rsq_reg[SH_R-1:0] == '0);
        hi_x    = CMPW'(hi_c);
        inner_x = CMPW'(inner_cut_sq_reg);
        outer_x = CMPW'(outer_cut_sq_reg);
        if (hi_x < inner_x)
        begin
            zone_next = ZONE_INNER;
        end
        else if (hi_x < outer_x || (hi_x == outer_x && lo_zero))
        begin
            zone_next = ZONE_OUTER;
        end
        else
        begin
            zone_next = ZONE_BEYOND;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zone_reg  <= zone_next;
            rq_reg    <= hi_c;
            rqsat_reg <= (hi_c <= RQW'(1));
        end
    end

    // Reciprocal of the squared distance.
    logic [MAG_W-1:0] quot28, r2_28, r2_31, r2_41;
    logic             rqsat28;

    lj2z_div #(.DW(RQW)) u_div (
        .clk(clk), .en(en), .divisor(rq_reg), .quot(quot28)
    );

    lj2z_delay #(.W(1), .D(DIV_STAGES)) u_dl_rqsat (
        .clk(clk), .rst_n(rst_n), .en(en), .d(rqsat_reg), .q(rqsat28)
    );

    assign r2_28 = rqsat28 ? MAG_MAX : quot28;

    lj2z_delay #(.W(MAG_W), .D(3)) u_dl_r2a (
        .clk(clk), .rst_n(rst_n), .en(en), .d(r2_28), .q(r2_31)
    );
    lj2z_delay #(.W(MAG_W), .D(10)) u_dl_r2b (
        .clk(clk), .rst_n(rst_n), .en(en), .d(r2_31), .q(r2_41)
    );

    // r6 = (r2 * r2) * r2.
    logic [MAG_W-1:0] m1_mag, r6_34, r6_38;
    logic             m1_sat, r6_sat;

    lj2z_mul #(.SH(COEF_FRAC)) u_m1 (
        .clk(clk), .en(en), .a(r2_28), .b(r2_28), .sat_in(rqsat28),
        .mag(m1_mag), .sat_out(m1_sat)
    );
    lj2z_mul #(.SH(COEF_FRAC)) u_m2 (
        .clk(clk), .en(en), .a(m1_mag), .b(r2_31), .sat_in(m1_sat),
        .mag(r6_34), .sat_out(r6_sat)
    );
    lj2z_delay #(.W(MAG_W), .D(4)) u_dl_r6 (
        .clk(clk), .rst_n(rst_n), .en(en), .d(r6_34), .q(r6_38)
    );

    // Repulsive term and difference.
    logic [MAG_W-1:0] m3f_mag, m3e_mag;
    logic             m3f_sat, m3e_sat;
    logic [MAG_W-1:0] fd_reg, ed_reg;
    logic             fdneg_reg, edneg_reg, fsat38_reg, esat38_reg;

    lj2z_mul #(.SH(COEF_FRAC)) u_m3f (
        .clk(clk), .en(en), .a(force_rep_coef_reg), .b(r6_34), .sat_in(r6_sat),
        .mag(m3f_mag), .sat_out(m3f_sat)
    );
    lj2z_mul #(.SH(COEF_FRAC)) u_m3e (
        .clk(clk), .en(en), .a(energy_rep_coef_reg), .b(r6_34), .sat_in(1'b0),
        .mag(m3e_mag), .sat_out(m3e_sat)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fdneg_reg  <= (m3f_mag < force_att_coef_reg);
            fd_reg     <= (m3f_mag >= force_att_coef_reg) ? (m3f_mag - force_att_coef_reg)
                                                          : (force_att_coef_reg - m3f_mag);
            edneg_reg  <= (m3e_mag < energy_att_coef_reg);
            ed_reg     <= (m3e_mag >= energy_att_coef_reg) ? (m3e_mag - energy_att_coef_reg)
                                                           : (energy_att_coef_reg - m3e_mag);
            fsat38_reg <= m3f_sat;
            esat38_reg <= m3e_sat;
        end
    end

    // Products with r6, then r2 on the force path.
    logic [MAG_W-1:0] m4f_mag, m4e_mag, m5f_mag, e44_mag;
    logic             m4f_sat, m4e_sat, m5f_sat, e44_sat;

    lj2z_mul #(.SH(COEF_FRAC)) u_m4f (
        .clk(clk), .en(en), .a(fd_reg), .b(r6_38), .sat_in(fsat38_reg),
        .mag(m4f_mag), .sat_out(m4f_sat)
    );
    lj2z_mul #(.SH(COEF_FRAC)) u_m4e (
        .clk(clk), .en(en), .a(ed_reg), .b(r6_38), .sat_in(esat38_reg),
        .mag(m4e_mag), .sat_out(m4e_sat)
    );
    lj2z_mul #(.SH(COEF_FRAC)) u_m5f (
        .clk(clk), .en(en), .a(m4f_mag), .b(r2_41), .sat_in(m4f_sat),
        .mag(m5f_mag), .sat_out(m5f_sat)
    );
    lj2z_delay #(.W(MAG_W+1), .D(3)) u_dl_e44 (
        .clk(clk), .rst_n(rst_n), .en(en), .d({m4e_sat, m4e_mag}), .q({e44_sat, e44_mag})
    );

    // Bond factor and zone scale.
    logic [SCALE_W-1:0] bf44, scl47;
    zone_t              zone47, zone53;
    logic [MAG_W-1:0]   m6f_mag, m6e_mag, m7f_mag, m7e_mag;
    logic               m6f_sat, m6e_sat, m7f_sat, m7e_sat;

    lj2z_delay #(.W(SCALE_W), .D(43)) u_dl_bf (
        .clk(clk), .rst_n(rst_n), .en(en), .d(bf_reg), .q(bf44)
    );
    lj2z_delay #(.W(2), .D(43)) u_dl_zone_a (
        .clk(clk), .rst_n(rst_n), .en(en), .d(zone_reg), .q(zone47)
    );
    lj2z_delay #(.W(2), .D(6)) u_dl_zone_b (
        .clk(clk), .rst_n(rst_n), .en(en), .d(zone47), .q(zone53)
    );

    assign scl47 = (zone47 == ZONE_OUTER) ? outer_scale_reg : SCALE_ONE;

    lj2z_mul #(.SH(SCALE_FRAC)) u_m6f (
        .clk(clk), .en(en), .a(m5f_mag), .b(MAG_W'(bf44)), .sat_in(m5f_sat),
        .mag(m6f_mag), .sat_out(m6f_sat)
    );
    lj2z_mul #(.SH(SCALE_FRAC)) u_m6e (
        .clk(clk), .en(en), .a(e44_mag), .b(MAG_W'(bf44)), .sat_in(e44_sat),
        .mag(m6e_mag), .sat_out(m6e_sat)
    );
    lj2z_mul #(.SH(SCALE_FRAC)) u_m7f (
        .clk(clk), .en(en), .a(m6f_mag), .b(MAG_W'(scl47)), .sat_in(m6f_sat),
        .mag(m7f_mag), .sat_out(m7f_sat)
    );
    lj2z_mul #(.SH(SCALE_FRAC)) u_m7e (
        .clk(clk), .en(en), .a(m6e_mag), .b(MAG_W'(scl47)), .sat_in(m6e_sat),
        .mag(m7e_mag), .sat_out(m7e_sat)
    );

    // Force components.
    logic [3*COORD_W+2:0] dvec1, dvec50;
    logic [MAG_W-1:0]     fc_mag [3];
    logic [2:0]           fc_sat;
    logic [MAG_W-1:0]     e53_mag;
    logic                 e53_sat, fdneg53, edneg53;

    assign dvec1 = {neg_reg, mag_reg[2], mag_reg[1], mag_reg[0]};

    lj2z_delay #(.W(3*COORD_W+3), .D(49)) u_dl_disp (
        .clk(clk), .rst_n(rst_n), .en(en), .d(dvec1), .q(dvec50)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_force
        lj2z_mul #(.SH(COORD_FRAC_BITS)) u_m8 (
            .clk(clk), .en(en), .a(MAG_W'(dvec50[k*COORD_W +: COORD_W])), .b(m7f_mag),
            .sat_in(m7f_sat), .mag(fc_mag[k]), .sat_out(fc_sat[k])
        );
    end

    lj2z_delay #(.W(MAG_W+1), .D(3)) u_dl_e53 (
        .clk(clk), .rst_n(rst_n), .en(en), .d({m7e_sat, m7e_mag}), .q({e53_sat, e53_mag})
    );

    lj2z_delay #(.W(2), .D(15)) u_dl_sign (
        .clk(clk), .rst_n(rst_n), .en(en), .d({fdneg_reg, edneg_reg}), .q({fdneg53, edneg53})
    );

    logic [2:0]   dneg53;
    logic         p_valid;

    lj2z_delay #(.W(3), .D(3)) u_dl_dneg (
        .clk(clk), .rst_n(rst_n), .en(en), .d(dvec50[3*COORD_W +: 3]), .q(dneg53)
    );

    lj2z_delay #(.W(1), .D(PIPE_D)) u_dl_valid (
        .clk(clk), .rst_n(rst_n), .en(en), .d(in_valid), .q(p_valid)
    );

    // Final conversion to signed words.
    result_t          p_data;
    logic [MAG_W-1:0] fw [3];
    logic [2:0]       fclip;
    logic             fneg;
    logic             esat_all;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fneg     = dneg53[k] ^ fdneg53;
            fw[k]    = out_word(fneg, fc_mag[k]);
            fclip[k] = out_clip(fneg, fc_mag[k]);
        end
        esat_all = energy_enable_reg & (e53_sat | out_clip(edneg53, e53_mag));
        p_data.zone = zone53;
        if (zone53 == ZONE_BEYOND)
        begin
            p_data.force_x     = '0;
            p_data.force_y     = '0;
            p_data.force_z     = '0;
            p_data.pair_energy = '0;
            p_data.saturated   = 1'b0;
        end
        else
        begin
            p_data.force_x     = fw[0];
            p_data.force_y     = fw[1];
            p_data.force_z     = fw[2];
            p_data.pair_energy = energy_enable_reg ? out_word(edneg53, e53_mag) : '0;
            p_data.saturated   = (|fc_sat) | (|fclip) | esat_all;
        end
    end

    // Output register with a spare slot.
    logic pop, arrive;

    always_comb
    begin
        pop             = out_valid_reg && out_ready;
        arrive          = en && p_valid;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (arrive)
            begin
                out_valid_next = 1'b1;
                out_data_next  = p_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (arrive)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = p_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign force_x     = $signed(out_data_reg.force_x);
    assign force_y     = $signed(out_data_reg.force_y);
    assign force_z     = $signed(out_data_reg.force_z);
    assign pair_energy = $signed(out_data_reg.pair_energy);
    assign zone        = out_data_reg.zone;
    assign saturated   = out_data_reg.saturated;

    // The spare slot is only ever filled behind a waiting output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("spare slot holds a word while the output register is empty");

    a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zone == ZONE_BEYOND) |->
        (force_x == '0 && force_y == '0 && force_z == '0 && pair_energy == '0 && !saturated))
        else $error("pair beyond the cutoff gave a nonzero result");

    a_energy_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !energy_enable_reg) |-> (pair_energy == '0))
        else $error("pair energy nonzero while energy is disabled");

endmodule

// File: bench/tb_lj_pair_force_two_zone_core.sv
// Self-checking testbench for the two-zone Lennard-Jones pair force core.
module tb_lj_pair_force_two_zone_core;
    import lj2z_pkg::*;

    localparam int FRAC = 24;
    localparam logic [63:0] ONE_Q48 = 64'h1_0000_0000_0000;

    typedef struct {
        logic [47:0] fx, fy, fz, en;
        logic [1:0]  zn;
        logic        sat;
    } pair_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MAG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [COORD_W-1:0] disp_x = '0, disp_y = '0, disp_z = '0;
    logic [SCALE_W-1:0] bond_factor = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [MAG_W-1:0] force_x, force_y, force_z, pair_energy;
    logic [1:0] zone;
    logic saturated;

    logic [47:0] inner_cut, outer_cut, f_rep, f_att, e_rep, e_att;
    logic [15:0] outer_scale;
    logic energy_on;

    pair_result_t expected_q[$];
    int mismatches = 0;
    int burst_left = 0;

    lj_pair_force_two_zone_core #(.COORD_FRAC_BITS(FRAC)) dut (.*);

    always #5 clk = ~clk;

    function automatic logic [47:0] scaled_mul(input logic [47:0] a, input logic [47:0] b,
                                              input int sh, inout logic sat);
        logic [95:0] p;
        p = ({48'd0, a} * {48'd0, b}) >> sh;
        if (p > {48'd0, MAG_MAX}) begin
            sat = 1'b1;
            return MAG_MAX;
        end
        return p[47:0];
    endfunction

    function automatic logic [47:0] to_signed_out(input logic neg, input logic [47:0] m,
                                                 inout logic sat);
        if (!neg) begin
            if (m > OUT_POS_MAX) begin
                sat = 1'b1;
                m = OUT_POS_MAX;
            end
            return m;
        end
        if (m > OUT_NEG_MAG) begin
            sat = 1'b1;
            m = OUT_NEG_MAG;
        end
        return ~m + 48'd1;
    endfunction

    function automatic pair_result_t lj_force(input logic [31:0] dx, input logic [31:0] dy,
                                              input logic [31:0] dz, input logic [15:0] bf);
        pair_result_t r;
        logic [31:0] d[3];
        logic [31:0] mag[3];
        logic neg[3];
        logic [65:0] rsq;
        logic [63:0] rq, r2w;
        logic [47:0] r2, r6, t, fmag, emag, cm;
        logic fneg, eneg, sat, esat;
        int sh;
        sh = 2 * FRAC - 24;
        d[0] = dx; d[1] = dy; d[2] = dz;
        rsq = '0;
        sat = 1'b0;
        esat = 1'b0;
        r = '{default: '0};
        for (int k = 0; k < 3; k++) begin
            neg[k] = d[k][31];
            mag[k] = neg[k] ? -d[k] : d[k];
            rsq += {34'd0, mag[k]} * {34'd0, mag[k]};
        end
        rq = 64'(rsq >> sh);
        if (rq < {16'd0, inner_cut})
            r.zn = ZONE_INNER;
        else if (rq < {16'd0, outer_cut} ||
                 (rq == {16'd0, outer_cut} && (rsq & ((66'd1 << sh) - 66'd1)) == '0))
            r.zn = ZONE_OUTER;
        else
            r.zn = ZONE_BEYOND;
        if (r.zn == ZONE_BEYOND)
            return r;
        if (rq == 0 || ONE_Q48 / rq > {16'd0, MAG_MAX}) begin
            sat = 1'b1;
            r2 = MAG_MAX;
        end else begin
            r2w = ONE_Q48 / rq;
            r2 = r2w[47:0];
        end
        t = scaled_mul(r2, r2, 24, sat);
        r6 = scaled_mul(t, r2, 24, sat);
        t = scaled_mul(f_rep, r6, 24, sat);
        fneg = t < f_att;
        fmag = fneg ? f_att - t : t - f_att;
        fmag = scaled_mul(fmag, r6, 24, sat);
        fmag = scaled_mul(fmag, r2, 24, sat);
        fmag = scaled_mul(fmag, {32'd0, bf}, 15, sat);
        if (r.zn == ZONE_OUTER)
            fmag = scaled_mul(fmag, {32'd0, outer_scale}, 15, sat);
        fneg = fneg && fmag != 0;
        for (int k = 0; k < 3; k++) begin
            cm = scaled_mul({16'd0, mag[k]}, fmag, FRAC, sat);
            t = to_signed_out((neg[k] != fneg) && cm != 0, cm, sat);
            if (k == 0) r.fx = t;
            else if (k == 1) r.fy = t;
            else r.fz = t;
        end
        if (energy_on) begin
            t = scaled_mul(e_rep, r6, 24, esat);
            eneg = t < e_att;
            emag = eneg ? e_att - t : t - e_att;
            emag = scaled_mul(emag, r6, 24, esat);
            emag = scaled_mul(emag, {32'd0, bf}, 15, esat);
            if (r.zn == ZONE_OUTER)
                emag = scaled_mul(emag, {32'd0, outer_scale}, 15, esat);
            r.en = to_signed_out(eneg && emag != 0, emag, esat);
        end
        r.sat = sat || esat;
        return r;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [47:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_INNER_CUT_SQ:    inner_cut = value;
            REG_OUTER_CUT_SQ:    outer_cut = value;
            REG_FORCE_REP_COEF:  f_rep = value;
            REG_FORCE_ATT_COEF:  f_att = value;
            REG_ENERGY_REP_COEF: e_rep = value;
            REG_ENERGY_ATT_COEF: e_att = value;
            REG_OUTER_SCALE:     outer_scale = value[15:0];
            REG_ENERGY_ENABLE:   energy_on = value[0];
            default: ;
        endcase
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic load_setup(input logic [47:0] ic, input logic [47:0] oc,
                              input logic [47:0] fr, input logic [47:0] fa,
                              input logic [47:0] er, input logic [47:0] ea,
                              input logic [15:0] os, input logic ee);
        drain();
        write_reg(REG_INNER_CUT_SQ, ic);
        write_reg(REG_OUTER_CUT_SQ, oc);
        write_reg(REG_FORCE_REP_COEF, fr);
        write_reg(REG_FORCE_ATT_COEF, fa);
        write_reg(REG_ENERGY_REP_COEF, er);
        write_reg(REG_ENERGY_ATT_COEF, ea);
        write_reg(REG_OUTER_SCALE, {32'd0, os});
        write_reg(REG_ENERGY_ENABLE, {47'd0, ee});
        cfg_we <= 1'b0;
    endtask

    task automatic send_pair(input logic [31:0] dx, input logic [31:0] dy,
                             input logic [31:0] dz, input logic [15:0] bf);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        disp_x <= dx;
        disp_y <= dy;
        disp_z <= dz;
        bond_factor <= bf;
        expected_q.push_back(lj_force(dx, dy, dz, bf));
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
            default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    task automatic test_directed;
        load_setup(48'h4_000000, 48'h9_000000, 48'h30_000000, 48'h18_000000,
                   48'h4_000000, 48'h4_000000, 16'd32768, 1'b1);
        send_pair(32'h0100_0000, 32'h0, 32'h0, 16'd32768);
        send_pair(32'h0, 32'hFF00_0000, 32'h0, 16'd32768);
        send_pair(32'h0, 32'h0, 32'h0, 16'd32768);
        send_pair(32'h0, 32'h0, 32'h1, 16'd32768);
        send_pair(32'h0280_0000, 32'h0, 32'h0, 16'd32768);
        send_pair(32'h0300_0000, 32'h0, 32'h0, 16'd16384);
        send_pair(32'h0300_0001, 32'h0, 32'h0, 16'd32768);
        send_pair(32'h0200_0000, 32'h0, 32'h0, 16'd32768);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
        send_pair(32'h0080_0000, 32'hFF80_0000, 32'h0040_0000, 16'hFFFF);
        send_pair(32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 16'd32768);
        load_setup(48'h9_000000, 48'h4_000000, MAG_MAX, MAG_MAX, MAG_MAX, 48'h0,
                   16'hFFFF, 1'b1);
        send_pair(32'h0100_0000, 32'h0, 32'h0, 16'd32768);
        send_pair(32'h0010_0000, 32'h0010_0000, 32'h0, 16'hFFFF);
        send_pair(32'h0280_0000, 32'h0, 32'h0, 16'd32768);
        load_setup(MAG_MAX, MAG_MAX, 48'h0, MAG_MAX, 48'h0, MAG_MAX, 16'h0, 1'b0);
        send_pair(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 16'd32768);
        send_pair(32'h8000_0000, 32'h0, 32'h0, 16'd32768);
        load_setup(48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 16'd32768, 1'b1);
        send_pair(32'h0, 32'h0, 32'h0, 16'd32768);
        send_pair(32'h0, 32'h0, 32'h1, 16'd32768);
    endtask

    task automatic test_random;
        for (int phase = 0; phase < 6; phase++) begin
            load_setup(48'($urandom_range(1, 20)) << 24, 48'($urandom_range(10, 40)) << 24,
                       48'({$urandom(), $urandom()} >> (16 + $urandom_range(0, 16))),
                       48'({$urandom(), $urandom()} >> (16 + $urandom_range(0, 16))),
                       48'({$urandom(), $urandom()} >> (16 + $urandom_range(0, 16))),
                       48'({$urandom(), $urandom()} >> (16 + $urandom_range(0, 16))),
                       16'($urandom()), 1'($urandom()));
            for (int i = 0; i < 300; i++)
                send_pair(rand_coord($urandom_range(0, 4)), rand_coord($urandom_range(0, 4)),
                          rand_coord($urandom_range(0, 4)),
                          $urandom_range(0, 3) == 0 ? 16'($urandom()) :
                          16'($urandom_range(0, 32768)));
        end
    endtask

    always @(posedge clk) begin
        case ($urandom_range(0, 3))
            0: out_ready <= ($urandom_range(0, 9) < 2);
            1: out_ready <= 1'b1;
            default: out_ready <= ($urandom_range(0, 9) < 7);
        endcase
    end

    always @(posedge clk) begin
        pair_result_t exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: zone %0d", zone);
            end else begin
                exp_r = expected_q.pop_front();
                if (force_x !== exp_r.fx || force_y !== exp_r.fy || force_z !== exp_r.fz ||
                    pair_energy !== exp_r.en || zone !== exp_r.zn ||
                    saturated !== exp_r.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp f=%h %h %h e=%h z=%0d s=%b got f=%h %h %h e=%h z=%0d s=%b",
                                 exp_r.fx, exp_r.fy, exp_r.fz, exp_r.en, exp_r.zn, exp_r.sat,
                                 force_x, force_y, force_z, pair_energy, zone, saturated);
                end
            end
        end
    end

    initial begin
        inner_cut = '0; outer_cut = '0; f_rep = '0; f_att = '0; e_rep = '0; e_att = '0;
        outer_scale = SCALE_ONE;
        energy_on = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_pair(32'h0100_0000, 32'h0, 32'h0, 16'd32768);
        test_directed();
        test_random();
        drain();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// File: filelist.f
rtl/lj2z_pkg.sv
rtl/lj2z_delay.sv
rtl/lj2z_mul.sv
rtl/lj2z_div.sv
rtl/lj_pair_force_two_zone_core.sv
bench/tb_lj_pair_force_two_zone_core.sv
